// File: hdl/irfd_pkg.sv
// Shared types, timing windows and helper for the IR remote frame decoder.
// No dependencies; imported by irfd_track and ir_remote_frame_decoder.
`timescale 1ns / 1ps

package irfd_pkg;

	localparam int unsigned FRAME_DUR_LIMIT_DEF = 256;

	localparam int unsigned DUR_W = 16;
	localparam int unsigned PROTO_W = 2;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ADDR_W = 13;
	localparam int unsigned CMD_W = 8;
	localparam int unsigned BITCNT_W = 9;
	localparam int unsigned SIRC_MAX_BITS = 20;
	localparam int unsigned SIRC_CMD_BITS = 7;

	// first bad SIRC space, 9 bits; all ones means none seen
	localparam int unsigned BAD_W = 9;
	localparam logic [BAD_W-1:0] NONE_SEEN = '1;

	// result beat: value, address, command, bit_count, header fields, 95 bits -> 96
	localparam int unsigned RES_TDATA_W = 96;

	localparam logic [PROTO_W-1:0] PROTO_NEC = 2'd0;
	localparam logic [PROTO_W-1:0] PROTO_VARIANT = 2'd1;
	localparam logic [PROTO_W-1:0] PROTO_SIRC = 2'd2;
	localparam logic [PROTO_W-1:0] PROTO_UNKNOWN = 2'd3;

	// nominal times in microseconds
	localparam int unsigned T_HDR_LONG = 9000;
	localparam int unsigned T_HDR_SHORT = 4500;
	localparam int unsigned T_SIRC_HDR = 2400;
	localparam int unsigned T_SIRC_ZERO = 600;
	localparam int unsigned T_SIRC_ONE = 1200;
	localparam int unsigned T_PD_UNIT = 560;
	localparam int unsigned T_PD_ONE = 1690;

	// exclusive window 75% .. 125%, bounds truncated
	localparam int unsigned HDR_LONG_LO = T_HDR_LONG * 75 / 100;
	localparam int unsigned HDR_LONG_HI = T_HDR_LONG * 125 / 100;
	localparam int unsigned HDR_SHORT_LO = T_HDR_SHORT * 75 / 100;
	localparam int unsigned HDR_SHORT_HI = T_HDR_SHORT * 125 / 100;
	localparam int unsigned SIRC_HDR_LO = T_SIRC_HDR * 75 / 100;
	localparam int unsigned SIRC_HDR_HI = T_SIRC_HDR * 125 / 100;
	localparam int unsigned SIRC_ZERO_LO = T_SIRC_ZERO * 75 / 100;
	localparam int unsigned SIRC_ZERO_HI = T_SIRC_ZERO * 125 / 100;
	localparam int unsigned SIRC_ONE_LO = T_SIRC_ONE * 75 / 100;
	localparam int unsigned SIRC_ONE_HI = T_SIRC_ONE * 125 / 100;
	localparam int unsigned PD_UNIT_LO = T_PD_UNIT * 75 / 100;
	localparam int unsigned PD_UNIT_HI = T_PD_UNIT * 125 / 100;
	localparam int unsigned PD_ONE_LO = T_PD_ONE * 75 / 100;
	localparam int unsigned PD_ONE_HI = T_PD_ONE * 125 / 100;

	// frame length limits
	localparam int unsigned PD_MIN_COUNT = 67;
	localparam int unsigned PD_LAST_MARK = 64;
	localparam int unsigned PD_LAST_SPACE = 65;
	localparam int unsigned PD_BITS = 32;
	localparam int unsigned SIRC_MIN_COUNT = 25;
	localparam int unsigned BAD_POS_LIMIT = 511;

	typedef struct packed {
		logic [PROTO_W-1:0]  protocol;
		logic [VALUE_W-1:0]  value;
		logic [ADDR_W-1:0]   address;
		logic [CMD_W-1:0]    command;
		logic [BITCNT_W-1:0] bit_count;
		logic [DUR_W-1:0]    header_mark;
		logic [DUR_W-1:0]    header_space;
		logic                header_valid;
	} irfd_result_t;

	function automatic logic near_time(input logic [DUR_W-1:0] d, input int unsigned lo,
		input int unsigned hi);
		return (32'(d) > lo) && (32'(d) < hi);
	endfunction

endpackage

// File: hdl/irfd_track.sv
// Per-frame tracking state of the IR decoder and the end-of-frame decision.
// Depends on irfd_pkg. Result is combinational from the next state.
`timescale 1ns / 1ps

module irfd_track #(
	parameter int unsigned FRAME_DUR_LIMIT = irfd_pkg::FRAME_DUR_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [irfd_pkg::DUR_W-1:0]    duration_us,
	input  logic                          last,
	output irfd_pkg::irfd_result_t        result
);
	import irfd_pkg::*;

	localparam int unsigned POS_W = $clog2(FRAME_DUR_LIMIT + 1);

	logic [POS_W-1:0]         position_q, position_n;
	logic                     nec_ok_q, nec_ok_n;
	logic                     variant_ok_q, variant_ok_n;
	logic [PD_BITS-1:0]       pd_bits_q, pd_bits_n;
	logic                     sirc_marks_ok_q, sirc_marks_ok_n;
	logic [SIRC_MAX_BITS-1:0] sirc_bits_q, sirc_bits_n;
	logic [BAD_W-1:0]         sirc_bad_q, sirc_bad_n;
	logic [DUR_W-1:0]         first_mark_q, first_mark_n;
	logic [DUR_W-1:0]         first_space_q, first_space_n;

	logic [31:0] p32;
	logic [31:0] count32;
	logic [31:0] bits32;
	logic        take;
	logic        sirc_len_ok;
	logic [SIRC_MAX_BITS-1:0] sirc_mask;
	logic [SIRC_MAX_BITS-1:0] sirc_val;

	assign p32 = 32'(position_q);
	assign take = 32'(position_q) < FRAME_DUR_LIMIT;

	always_comb begin
		position_n = position_q;
		nec_ok_n = nec_ok_q;
		variant_ok_n = variant_ok_q;
		pd_bits_n = pd_bits_q;
		sirc_marks_ok_n = sirc_marks_ok_q;
		sirc_bits_n = sirc_bits_q;
		sirc_bad_n = sirc_bad_q;
		first_mark_n = first_mark_q;
		first_space_n = first_space_q;
		if (take) begin
			position_n = position_q + 1'b1;
			if (p32 == 32'd0) begin
				first_mark_n = duration_us;
				if (!near_time(duration_us, HDR_LONG_LO, HDR_LONG_HI)) nec_ok_n = 1'b0;
				if (!near_time(duration_us, HDR_SHORT_LO, HDR_SHORT_HI)) variant_ok_n = 1'b0;
				if (!near_time(duration_us, SIRC_HDR_LO, SIRC_HDR_HI)) sirc_marks_ok_n = 1'b0;
			end else if (p32 == 32'd1) begin
				first_space_n = duration_us;
				if (!near_time(duration_us, HDR_SHORT_LO, HDR_SHORT_HI)) begin
					nec_ok_n = 1'b0;
					variant_ok_n = 1'b0;
				end
				if (!near_time(duration_us, SIRC_ZERO_LO, SIRC_ZERO_HI)) sirc_marks_ok_n = 1'b0;
			end else if (!position_q[0]) begin
				// mark
				if (p32 <= PD_LAST_MARK && !near_time(duration_us, PD_UNIT_LO, PD_UNIT_HI)) begin
					nec_ok_n = 1'b0;
					variant_ok_n = 1'b0;
				end
				if (near_time(duration_us, SIRC_ONE_LO, SIRC_ONE_HI)) begin
					for (int i = 0; i < SIRC_MAX_BITS; i++) begin
						if (p32 == 32'(2 + 2 * i)) sirc_bits_n[i] = 1'b1;
					end
				end else if (!near_time(duration_us, SIRC_ZERO_LO, SIRC_ZERO_HI)) begin
					sirc_marks_ok_n = 1'b0;
				end
			end else begin
				// space
				if (p32 <= PD_LAST_SPACE) begin
					if (near_time(duration_us, PD_ONE_LO, PD_ONE_HI)) begin
						for (int i = 0; i < PD_BITS; i++) begin
							if (p32 == 32'(3 + 2 * i)) pd_bits_n[i] = 1'b1;
						end
					end else if (!near_time(duration_us, PD_UNIT_LO, PD_UNIT_HI)) begin
						nec_ok_n = 1'b0;
						variant_ok_n = 1'b0;
					end
				end
				if (!near_time(duration_us, SIRC_ZERO_LO, SIRC_ZERO_HI)
					&& sirc_bad_q == NONE_SEEN && p32 < BAD_POS_LIMIT) begin
					sirc_bad_n = p32[BAD_W-1:0];
				end
			end
		end
	end

	// end-of-frame decision on the state that includes this beat
	assign count32 = 32'(position_n);
	assign bits32 = (count32 - 32'd1) >> 1;
	assign sirc_len_ok = (bits32 == 32'd12 && 32'(sirc_bad_n) > 32'd23)
		|| (bits32 == 32'd15 && 32'(sirc_bad_n) > 32'd29)
		|| (bits32 == 32'd20 && 32'(sirc_bad_n) > 32'd39);

	always_comb begin
		case (bits32[4:0])
			5'd12:   sirc_mask = SIRC_MAX_BITS'(20'h00FFF);
			5'd15:   sirc_mask = SIRC_MAX_BITS'(20'h07FFF);
			default: sirc_mask = '1;
		endcase
	end
	assign sirc_val = sirc_bits_n & sirc_mask;

	always_comb begin
		result = '0;
		if (count32 >= PD_MIN_COUNT && (nec_ok_n || variant_ok_n)) begin
			result.protocol = nec_ok_n ? PROTO_NEC : PROTO_VARIANT;
			result.value = pd_bits_n;
			result.address = ADDR_W'(pd_bits_n[7:0]);
			result.command = pd_bits_n[23:16];
			result.bit_count = BITCNT_W'(PD_BITS);
		end else if (count32 >= SIRC_MIN_COUNT && sirc_marks_ok_n && sirc_len_ok) begin
			result.protocol = PROTO_SIRC;
			result.value = VALUE_W'(sirc_val);
			result.address = sirc_val[SIRC_MAX_BITS-1:SIRC_CMD_BITS];
			result.command = CMD_W'(sirc_val[SIRC_CMD_BITS-1:0]);
			result.bit_count = bits32[BITCNT_W-1:0];
		end else begin
			result.protocol = PROTO_UNKNOWN;
			result.bit_count = count32[BITCNT_W-1:0];
			if (count32 >= 32'd2) begin
				result.header_mark = first_mark_n;
				result.header_space = first_space_n;
				result.header_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			nec_ok_q <= 1'b1;
			variant_ok_q <= 1'b1;
			pd_bits_q <= '0;
			sirc_marks_ok_q <= 1'b1;
			sirc_bits_q <= '0;
			sirc_bad_q <= NONE_SEEN;
			first_mark_q <= '0;
			first_space_q <= '0;
		end else if (step) begin
			if (last) begin
				position_q <= '0;
				nec_ok_q <= 1'b1;
				variant_ok_q <= 1'b1;
				pd_bits_q <= '0;
				sirc_marks_ok_q <= 1'b1;
				sirc_bits_q <= '0;
				sirc_bad_q <= NONE_SEEN;
				first_mark_q <= '0;
				first_space_q <= '0;
			end else begin
				position_q <= position_n;
				nec_ok_q <= nec_ok_n;
				variant_ok_q <= variant_ok_n;
				pd_bits_q <= pd_bits_n;
				sirc_marks_ok_q <= sirc_marks_ok_n;
				sirc_bits_q <= sirc_bits_n;
				sirc_bad_q <= sirc_bad_n;
				first_mark_q <= first_mark_n;
				first_space_q <= first_space_n;
			end
		end
	end

endmodule

// File: hdl/ir_remote_frame_decoder.sv
// Top level of the IR remote frame decoder: input register, frame tracker, result register.
// Depends on irfd_pkg and irfd_track.
`timescale 1ns / 1ps

// Takes one mark or space duration (microseconds) per beat, marks first, tlast on the final
// duration of a frame, and gives one result beat per frame: NEC, the 4.5 ms header variant,
// SIRC 12/15/20 bit, or unknown with the header durations. One duration is taken every clock
// cycle unless a stalled last duration holds the input register. The result is registered: the
// input register holds the last duration, then the tracker's decision loads the result register.
// Only a frame's last duration waits on a result that has not been taken yet; durations past
// FRAME_DUR_LIMIT are dropped and the count saturates.
module ir_remote_frame_decoder #(
	parameter int unsigned FRAME_DUR_LIMIT = irfd_pkg::FRAME_DUR_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [irfd_pkg::DUR_W-1:0]          s_axis_tdata,  // [15:0] duration_us
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] value, [44:32] address, [52:45] command, [61:53] bit_count,
	// [77:62] header_mark, [93:78] header_space, [94] header_valid, [95] zero
	output logic [irfd_pkg::RES_TDATA_W-1:0]    m_axis_tdata,
	output logic [irfd_pkg::PROTO_W-1:0]        m_axis_tuser   // [1:0] protocol
);
	import irfd_pkg::*;

	logic               valid_s1;
	logic [DUR_W-1:0]   dur_s1;
	logic               last_s1;
	logic               adv_s1;
	logic               step;
	irfd_result_t       res;
	irfd_result_t       res_q;
	logic               out_valid_q;

	// a non-last beat never needs the result register
	assign adv_s1 = !last_s1 || !out_valid_q || m_axis_tready;
	assign step = valid_s1 && adv_s1;
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			dur_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	irfd_track #(
		.FRAME_DUR_LIMIT(FRAME_DUR_LIMIT)
	) u_track (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.duration_us(dur_s1),
		.last(last_s1),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = res_q.protocol;
	assign m_axis_tdata = {1'b0, res_q.header_valid, res_q.header_space, res_q.header_mark,
		res_q.bit_count, res_q.command, res_q.address, res_q.value};

endmodule

// File: sim/testbench.sv
// Self-checking bench for ir_remote_frame_decoder: streams mark/space frames with random
// gaps and result stalls, predicts each decoded frame and compares it field by field.
// Depends on irfd_pkg and the decoder RTL in hdl/.
`timescale 1ns / 1ps

module testbench;
	import irfd_pkg::*;

	// nominal times, microseconds
	localparam int unsigned NOM_LEADER = 9000;
	localparam int unsigned NOM_HALF_LEADER = 4500;
	localparam int unsigned NOM_SIRC_START = 2400;
	localparam int unsigned NOM_SIRC_ONE = 1200;
	localparam int unsigned NOM_SIRC_ZERO = 600;
	localparam int unsigned NOM_BURST = 560;
	localparam int unsigned NOM_PD_ONE = 1690;

	localparam int unsigned PD_FRAME_LEN = 67;
	localparam int unsigned PD_MARK_END = 64;
	localparam int unsigned PD_SPACE_END = 65;
	localparam int unsigned SIRC_MIN_LEN = 25;
	localparam int unsigned BAD_POS_CAP = 511;
	localparam int unsigned NO_BAD_SPACE = 511;

	localparam int unsigned RANDOM_BEATS = 320;
	localparam int unsigned RANDOM_FRAMES_MIN = 6;

	typedef enum int unsigned {
		SINK_OPEN,
		SINK_BUSY,
		SINK_CHOKED,
		SINK_PERIODIC
	} sink_mode_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [DUR_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [RES_TDATA_W-1:0] m_axis_tdata;
	logic [PROTO_W-1:0] m_axis_tuser;

	logic [DUR_W-1:0] frame_q[$];
	int unsigned burst_left;
	int unsigned beats_sent;

	class frame_scoreboard;
		int unsigned pos;
		bit leader_ok;
		bit half_leader_ok;
		bit sirc_ok;
		logic [31:0] pd_bits;
		logic [19:0] sirc_bits;
		int unsigned first_bad_space;
		logic [DUR_W-1:0] mark0;
		logic [DUR_W-1:0] space0;
		irfd_result_t decoded_due[$];
		int unsigned mismatch_count;
		int unsigned results_seen;

		function new();
			restart();
			mismatch_count = 0;
			results_seen = 0;
		endfunction

		function void restart();
			pos = 0;
			leader_ok = 1'b1;
			half_leader_ok = 1'b1;
			sirc_ok = 1'b1;
			pd_bits = '0;
			sirc_bits = '0;
			first_bad_space = NO_BAD_SPACE;
			mark0 = '0;
			space0 = '0;
		endfunction

		static function bit in_window(logic [DUR_W-1:0] d, int unsigned nom);
			return (32'(d) > nom * 75 / 100) && (32'(d) < nom * 125 / 100);
		endfunction

		// called once per accepted duration beat
		function void absorb_duration(logic [DUR_W-1:0] d, logic last);
			irfd_result_t r;
			int unsigned k;
			int unsigned cnt;
			int unsigned nbits;
			logic [31:0] v;
			if (pos < FRAME_DUR_LIMIT_DEF) begin
				if (pos == 0) begin
					mark0 = d;
					if (!in_window(d, NOM_LEADER)) leader_ok = 1'b0;
					if (!in_window(d, NOM_HALF_LEADER)) half_leader_ok = 1'b0;
					if (!in_window(d, NOM_SIRC_START)) sirc_ok = 1'b0;
				end else if (pos == 1) begin
					space0 = d;
					if (!in_window(d, NOM_HALF_LEADER)) begin
						leader_ok = 1'b0;
						half_leader_ok = 1'b0;
					end
					if (!in_window(d, NOM_SIRC_ZERO)) sirc_ok = 1'b0;
				end else if (pos % 2 == 0) begin
					k = (pos - 2) / 2;
					if (pos <= PD_MARK_END && !in_window(d, NOM_BURST)) begin
						leader_ok = 1'b0;
						half_leader_ok = 1'b0;
					end
					if (in_window(d, NOM_SIRC_ONE)) begin
						if (k < 20) sirc_bits[k] = 1'b1;
					end else if (!in_window(d, NOM_SIRC_ZERO)) begin
						sirc_ok = 1'b0;
					end
				end else begin
					k = (pos - 3) / 2;
					if (pos <= PD_SPACE_END) begin
						if (in_window(d, NOM_PD_ONE)) begin
							pd_bits[k] = 1'b1;
						end else if (!in_window(d, NOM_BURST)) begin
							leader_ok = 1'b0;
							half_leader_ok = 1'b0;
						end
					end
					if (!in_window(d, NOM_SIRC_ZERO) && first_bad_space == NO_BAD_SPACE &&
						pos < BAD_POS_CAP)
						first_bad_space = pos;
				end
				pos++;
			end
			if (!last) return;

			cnt = pos;
			nbits = (cnt - 1) / 2;
			r = '0;
			if (cnt >= PD_FRAME_LEN && (leader_ok || half_leader_ok)) begin
				r.protocol = leader_ok ? PROTO_NEC : PROTO_VARIANT;
				r.value = pd_bits;
				r.address = 13'(pd_bits[7:0]);
				r.command = pd_bits[23:16];
				r.bit_count = 9'd32;
			end else if (cnt >= SIRC_MIN_LEN && sirc_ok &&
				(nbits == 12 || nbits == 15 || nbits == 20) &&
				first_bad_space > 2 * nbits - 1) begin
				v = 32'(sirc_bits) & ((32'd1 << nbits) - 32'd1);
				r.protocol = PROTO_SIRC;
				r.value = v;
				r.address = 13'(v >> 7);
				r.command = {1'b0, v[6:0]};
				r.bit_count = 9'(nbits);
			end else begin
				r.protocol = PROTO_UNKNOWN;
				r.bit_count = 9'(cnt);
				if (cnt >= 2) begin
					r.header_mark = mark0;
					r.header_space = space0;
					r.header_valid = 1'b1;
				end
			end
			decoded_due.push_back(r);
			restart();
		endfunction

		function void compare_field(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("frame %0d: %s expected %h, got %h", results_seen, what,
						want, got);
			end
		endfunction

		function void check_decoded(logic [RES_TDATA_W-1:0] data, logic [PROTO_W-1:0] user);
			irfd_result_t want;
			if (decoded_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result beat with no frame outstanding: tuser %h tdata %h",
						user, data);
				return;
			end
			want = decoded_due.pop_front();
			compare_field("protocol", 32'(want.protocol), 32'(user));
			compare_field("value", want.value, data[31:0]);
			compare_field("address", 32'(want.address), 32'(data[44:32]));
			compare_field("command", 32'(want.command), 32'(data[52:45]));
			compare_field("bit_count", 32'(want.bit_count), 32'(data[61:53]));
			compare_field("header_mark", 32'(want.header_mark), 32'(data[77:62]));
			compare_field("header_space", 32'(want.header_space), 32'(data[93:78]));
			compare_field("header_valid", 32'(want.header_valid), 32'(data[94]));
			compare_field("pad bit", 32'd0, 32'(data[95]));
			results_seen++;
		endfunction
	endclass

	frame_scoreboard sb;

	ir_remote_frame_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// duration strictly inside the window of a nominal time
	function automatic logic [DUR_W-1:0] jit(int unsigned nom);
		return 16'($urandom_range(nom * 125 / 100 - 1, nom * 75 / 100 + 1));
	endfunction

	// a value likely to miss: zero, full scale, an exact window bound, or anything
	function automatic logic [DUR_W-1:0] bad_value();
		int unsigned nom;
		case ($urandom_range(0, 6))
			0: nom = NOM_LEADER;
			1: nom = NOM_HALF_LEADER;
			2: nom = NOM_SIRC_START;
			3: nom = NOM_SIRC_ONE;
			4: nom = NOM_SIRC_ZERO;
			5: nom = NOM_BURST;
			default: nom = NOM_PD_ONE;
		endcase
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'(nom * 75 / 100);
			3: return 16'(nom * 125 / 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void build_pd(int unsigned leader, logic [31:0] v);
		frame_q.delete();
		frame_q.push_back(jit(leader));
		frame_q.push_back(jit(NOM_HALF_LEADER));
		for (int k = 0; k < 32; k++) begin
			frame_q.push_back(jit(NOM_BURST));
			frame_q.push_back(v[k] ? jit(NOM_PD_ONE) : jit(NOM_BURST));
		end
		frame_q.push_back(jit(NOM_BURST));
	endfunction

	// trailing space after the last bit is optional and unchecked
	function automatic void build_sirc(int unsigned nbits, logic [19:0] v, bit tail);
		frame_q.delete();
		frame_q.push_back(jit(NOM_SIRC_START));
		frame_q.push_back(jit(NOM_SIRC_ZERO));
		for (int k = 0; k < nbits; k++) begin
			frame_q.push_back(v[k] ? jit(NOM_SIRC_ONE) : jit(NOM_SIRC_ZERO));
			if (k < nbits - 1) frame_q.push_back(jit(NOM_SIRC_ZERO));
		end
		if (tail) frame_q.push_back(16'($urandom));
	endfunction

	function automatic void build_noise(int unsigned len);
		frame_q.delete();
		repeat (len) frame_q.push_back(16'($urandom));
	endfunction

	function automatic int unsigned sirc_width();
		case ($urandom_range(0, 2))
			0: return 12;
			1: return 15;
			default: return 20;
		endcase
	endfunction

	function automatic void damage_frame();
		int unsigned cut;
		case ($urandom_range(0, 5))
			0: begin
				cut = $urandom_range(frame_q.size() - 1, 1);
				while (frame_q.size() > cut) void'(frame_q.pop_back());
			end
			1: repeat ($urandom_range(10, 1)) frame_q.push_back(16'($urandom));
			default: frame_q[$urandom_range(frame_q.size() - 1, 0)] = bad_value();
		endcase
	endfunction

	// one duration beat; the sender may idle between bursts of random length
	task automatic send_beat(input logic [DUR_W-1:0] d, input logic l);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(60, 1);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		sb.absorb_duration(d, l);
		burst_left--;
		beats_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_beat(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic run_directed();
		build_pd(NOM_LEADER, 32'h0000_0000);
		send_frame();
		build_pd(NOM_LEADER, 32'hFFFF_FFFF);
		send_frame();
		build_pd(NOM_HALF_LEADER, 32'hA55A_3CC3);
		send_frame();
		build_sirc(12, 20'h00ABC, 1'b0);
		send_frame();
		// bad space after the last bit does not spoil the frame
		build_sirc(15, 20'h05A5A, 1'b1);
		frame_q[frame_q.size() - 1] = 16'd0;
		send_frame();
		build_sirc(20, 20'hFFFFF, 1'b0);
		send_frame();
		// lone duration: no header reported
		frame_q.delete();
		frame_q.push_back(16'hFFFF);
		send_frame();
		frame_q.delete();
		frame_q.push_back(16'h0000);
		frame_q.push_back(16'hFFFF);
		send_frame();
		// zero duration in a data space
		build_pd(NOM_LEADER, 32'h1234_5678);
		frame_q[7] = 16'd0;
		send_frame();
		// leader exactly on the lower bound misses, one above hits
		build_pd(NOM_LEADER, 32'h0F0F_F0F0);
		frame_q[0] = 16'(NOM_LEADER * 75 / 100);
		send_frame();
		build_pd(NOM_LEADER, 32'h0F0F_F0F0);
		frame_q[0] = 16'(NOM_LEADER * 75 / 100 + 1);
		send_frame();
		build_pd(NOM_LEADER, 32'h8000_0001);
		frame_q[3] = 16'(NOM_PD_ONE * 125 / 100);
		send_frame();
		// SIRC with a bad space in the middle
		build_sirc(12, 20'h00F0F, 1'b0);
		frame_q[9] = 16'(NOM_SIRC_ZERO * 125 / 100);
		send_frame();
		// one duration short of a pulse-distance frame
		build_pd(NOM_LEADER, 32'hC3C3_5A5A);
		void'(frame_q.pop_back());
		send_frame();
		// overlong frames: tail ignored, count saturates
		build_pd(NOM_LEADER, 32'hDEAD_BEEF);
		repeat (240) frame_q.push_back(16'($urandom));
		send_frame();
		build_noise(FRAME_DUR_LIMIT_DEF + 4);
		send_frame();
	endtask

	task automatic run_random();
		int unsigned start;
		int unsigned frames;
		int unsigned pick;
		start = beats_sent;
		frames = 0;
		while (beats_sent - start < RANDOM_BEATS || frames < RANDOM_FRAMES_MIN) begin
			pick = $urandom_range(99, 0);
			if (pick < 30) begin
				build_pd(NOM_LEADER, $urandom);
			end else if (pick < 45) begin
				build_pd(NOM_HALF_LEADER, $urandom);
			end else if (pick < 75) begin
				build_sirc(sirc_width(), 20'($urandom), 1'($urandom));
			end else if (pick < 85) begin
				build_noise($urandom_range(80, 1));
			end else begin
				case ($urandom_range(0, 2))
					0: build_pd(NOM_LEADER, $urandom);
					1: build_pd(NOM_HALF_LEADER, $urandom);
					default: build_sirc(sirc_width(), 20'($urandom), 1'($urandom));
				endcase
				damage_frame();
			end
			// pulse-distance frames tolerate trailing durations
			if (pick < 45 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(6, 1)) frame_q.push_back(16'($urandom));
			send_frame();
			frames++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_decoded(m_axis_tdata, m_axis_tuser);
	end

	// result side stalls in segments of differing character
	initial begin : result_sink
		sink_mode_t mode;
		int unsigned span;
		int unsigned t;
		m_axis_tready <= 1'b0;
		t = 0;
		forever begin
			mode = sink_mode_t'($urandom_range(3, 0));
			span = $urandom_range(200, 20);
			repeat (span) begin
				@(posedge clk);
				t++;
				case (mode)
					SINK_OPEN: m_axis_tready <= 1'b1;
					SINK_BUSY: m_axis_tready <= ($urandom_range(3, 0) != 0);
					SINK_CHOKED: m_axis_tready <= ($urandom_range(7, 0) == 0);
					default: m_axis_tready <= (t % 24 < 6);
				endcase
			end
		end
	end

	initial begin : stimulus
		sb = new();
		burst_left = 0;
		beats_sent = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		s_axis_tvalid <= 1'b0;
		while (sb.decoded_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
hdl/irfd_pkg.sv
hdl/irfd_track.sv
hdl/ir_remote_frame_decoder.sv
sim/testbench.sv
